@@ rtl/pc1_pkg.sv @@
// shared constants, types and helpers of the pc1 byte decryptor
`default_nettype none

package pc1_pkg;

    localparam int KEY_BYTES = 16;
    localparam int KEY_WORDS = KEY_BYTES / 2;
    localparam int RND_W     = $clog2(KEY_WORDS);
    localparam int NUM_REGS  = 4;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 64;

    localparam logic [15:0] MUL_A = 16'h4E35;
    localparam logic [15:0] MUL_B = 16'h015A;

    typedef logic [NUM_REGS-1:0][DATA_W-1:0] t_key_regs;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD
    } t_state;

    typedef struct packed {
        logic             load;
        logic             round;
        logic             fold;
        logic [RND_W-1:0] rnd;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

    // low 16 bits of a product
    function automatic logic [15:0] mul16(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        p = a * b;
        return p[15:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/pc1_regs.sv @@
// key registers behind the apb-style configuration port
`default_nettype none

module pc1_regs
    import pc1_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_key_regs              o_key_regs
);

    t_key_regs r_key_regs;
    logic      wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_regs <= '0;
        end else if (wr_en) begin
            r_key_regs[paddr[ADDR_W-1:3]] <= pwdata;
        end
    end

    assign prdata     = r_key_regs[paddr[ADDR_W-1:3]];
    assign o_key_regs = r_key_regs;

endmodule

`default_nettype wire

@@ rtl/pc1_ctrl.sv @@
// sequencer: accept, one round per cycle, fold and hand over
`default_nettype none

module pc1_ctrl
    import pc1_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_dp_status i_status,
    output logic            o_stall,
    output t_dp_cmd         o_cmd
);

    t_state           r_state, n_state;
    logic [RND_W-1:0] r_rnd, n_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= '0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rnd       = r_rnd;
        o_stall     = 1'b1;
        o_cmd       = '0;
        o_cmd.rnd   = r_rnd;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_rnd      = '0;
                    n_state    = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (r_rnd == RND_W'(KEY_WORDS - 1)) begin
                    n_state = ST_FOLD;
                end else begin
                    n_rnd = r_rnd + 1'b1;
                end
            end
            ST_FOLD: begin
                // wait while the previous result still sits stalled
                if (!i_status.out_busy) begin
                    o_cmd.fold = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/pc1_dp.sv @@
// key store, chaining words, round unit and output register
`default_nettype none

module pc1_dp
    import pc1_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    input  wire logic [7:0] i_cipher_byte,
    input  wire logic       i_restart,
    input  wire t_key_regs  i_key_regs,
    input  wire logic       i_stall,
    output t_dp_status      o_status,
    output logic            o_valid,
    output logic      [7:0] o_plain_byte
);

    logic [7:0]  r_key [KEY_BYTES];
    logic [15:0] r_chain_mult;
    logic [15:0] r_chain_sum;
    logic [15:0] r_prev;
    logic [15:0] r_fold;
    logic [7:0]  r_cipher;
    logic [7:0]  r_plain;
    logic        r_out_valid;

    logic [RND_W:0] byte_idx;
    logic [15:0]    key_word;
    logic [15:0]    w;
    logic [15:0]    idx;
    logic [15:0]    mw;
    logic [15:0]    t;
    logic [15:0]    o;
    logic [15:0]    fold_next;
    logic [7:0]     plain;

    // one round of the cipher
    assign byte_idx  = {i_cmd.rnd, 1'b0};
    assign key_word  = {r_key[byte_idx], r_key[byte_idx + 1'b1]};
    assign w         = r_prev ^ key_word;
    assign idx       = r_chain_sum + 16'(i_cmd.rnd);
    assign mw        = mul16(MUL_B, w);
    assign t         = mul16(idx, MUL_A) + mw + r_chain_mult;
    assign o         = mul16(w, MUL_A) + 16'd1;
    assign fold_next = r_fold ^ o ^ t;

    assign plain = r_cipher ^ r_fold[15:8] ^ r_fold[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < KEY_BYTES; b++) begin
                r_key[b] <= '0;
            end
            r_chain_mult <= '0;
            r_chain_sum  <= '0;
        end else if (i_cmd.load) begin
            if (i_restart) begin
                for (int b = 0; b < KEY_BYTES; b++) begin
                    r_key[b] <= i_key_regs[2'(b >> 3)][8 * (7 - (b & 7)) +: 8];
                end
                r_chain_mult <= '0;
                r_chain_sum  <= '0;
            end
        end else if (i_cmd.round) begin
            r_chain_mult <= mw;
            r_chain_sum  <= t;
        end else if (i_cmd.fold) begin
            for (int b = 0; b < KEY_BYTES; b++) begin
                r_key[b] <= r_key[b] ^ plain;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cipher <= i_cipher_byte;
            r_prev   <= '0;
            r_fold   <= '0;
        end else if (i_cmd.round) begin
            r_prev <= o;
            r_fold <= fold_next;
        end
        if (i_cmd.fold) begin
            r_plain <= plain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fold) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_busy = r_out_valid && i_stall;
    assign o_valid           = r_out_valid;
    assign o_plain_byte      = r_plain;

endmodule

`default_nettype wire

@@ rtl/pc1_stream_byte_decrypt_core.sv @@
// top level of the pc1 stream byte decryptor
`default_nettype none

// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_cipher_byte, i_restart
// output    out        o_valid / i_stall  o_plain_byte
// config    in         psel / penable     paddr, pwdata, prdata (64-bit key words)
//
// an item passes one accept state, one round per key word through the shared
// round unit, and one fold state
// the round unit holds the chaining words, so items are worked one at a time
// the result register lets the next item enter while a result is stalled;
// the fold cycle waits only if the previous result is still not taken
// synchronous active-low reset clears key registers, key store and chaining words
// restart on an item reloads the key store from the registers before its rounds

module pc1_stream_byte_decrypt_core
    import pc1_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input item channel
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_cipher_byte,
    input  wire logic              i_restart,
    // result channel
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [7:0]        o_plain_byte,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    t_key_regs  key_regs;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // key words written over the bus, copied to the key store on restart
    pc1_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_key_regs (key_regs)
    );

    // sequencer: accept, rounds, fold
    pc1_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (dp_status),
        .o_stall  (o_stall),
        .o_cmd    (dp_cmd)
    );

    // round unit, key store and result register
    pc1_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_cipher_byte (i_cipher_byte),
        .i_restart     (i_restart),
        .i_key_regs    (key_regs),
        .i_stall       (i_stall),
        .o_status      (dp_status),
        .o_valid       (o_valid),
        .o_plain_byte  (o_plain_byte)
    );

endmodule

`default_nettype wire
